/* design/ddeo_pkg.sv */
// ----------------------------------------------------------------------------
// ddeo_pkg
// Shared types, constants and the CORDIC arctangent table for the odometry block.
// ----------------------------------------------------------------------------
package ddeo_pkg;

  localparam int unsigned CordicStepsDefault = 16;
  localparam logic [31:0] DistPerCountReset  = 32'd65536;
  localparam logic [31:0] AnglePerCountReset = 32'd65536;
  localparam logic [30:0] JumpLimitReset     = 31'd12000;
  localparam logic [30:0] GainQ30            = 31'd652032875;
  localparam logic [33:0] DsClamp            = 34'h2_0000_0000;

  // register indexes
  localparam logic [1:0] RegDistPerCount  = 2'd0;
  localparam logic [1:0] RegAnglePerCount = 2'd1;
  localparam logic [1:0] RegJumpLimit     = 2'd2;

  // classified sample handed from front to back
  typedef struct packed {
    logic        rejected;
    logic [32:0] sum;   // dl + dr, signed
    logic [32:0] diff;  // dr - dl, signed
  } ddeo_job_t;

  function automatic logic [31:0] atan_lookup(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/ddeo_if.sv */
// ----------------------------------------------------------------------------
// ddeo_in_if / ddeo_out_if
// Valid/ready channels for encoder samples and pose results.
// ----------------------------------------------------------------------------
interface ddeo_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_count;
  logic [31:0] right_count;
  modport source (output valid, left_count, right_count, input ready);
  modport sink (input valid, left_count, right_count, output ready);
endinterface

interface ddeo_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] heading;
  logic        sample_rejected;
  modport source (output valid, pos_x, pos_y, heading, sample_rejected, input ready);
  modport sink (input valid, pos_x, pos_y, heading, sample_rejected, output ready);
endinterface

/* design/ddeo_front.sv */
// ----------------------------------------------------------------------------
// ddeo_front
// Accepts counts, forms wrap-around deltas, checks the jump limit, pushes a job.
// ----------------------------------------------------------------------------
module ddeo_front import ddeo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ddeo_in_if.sink     in_ch,
  input  logic [30:0] jump_limit,
  input  logic        q_full,
  output logic        q_push,
  output ddeo_job_t   q_data
);

  logic [31:0] prev_left;
  logic [31:0] prev_right;
  logic [31:0] dl;
  logic [31:0] dr;
  logic [31:0] al;
  logic [31:0] ar;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // deltas as previous minus current, read signed
  assign dl = prev_left - in_ch.left_count;
  assign dr = prev_right - in_ch.right_count;
  assign al = dl[31] ? (32'd0 - dl) : dl;
  assign ar = dr[31] ? (32'd0 - dr) : dr;

  always_comb begin
    q_data.rejected = !((al < {1'b0, jump_limit}) && (ar < {1'b0, jump_limit}));
    q_data.sum      = {dl[31], dl} + {dr[31], dr};
    q_data.diff     = {dr[31], dr} - {dl[31], dl};
  end

  // take the new counts on every push, rejected or not
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left  <= '0;
      prev_right <= '0;
    end else if (q_push) begin
      prev_left  <= in_ch.left_count;
      prev_right <= in_ch.right_count;
    end
  end

endmodule

/* design/ddeo_queue.sv */
// ----------------------------------------------------------------------------
// ddeo_queue
// Two-entry queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module ddeo_queue import ddeo_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ddeo_job_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output ddeo_job_t pop_data
);

  ddeo_job_t   entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* design/ddeo_back.sv */
// ----------------------------------------------------------------------------
// ddeo_back
// Sequencer: path length and heading products, CORDIC rotation, accumulation.
// ----------------------------------------------------------------------------
module ddeo_back import ddeo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  ddeo_job_t   q_data,
  output logic        q_pop,
  input  logic [31:0] distance_per_count,
  input  logic [31:0] angle_per_count,
  ddeo_out_if.source  out_ch
);

  localparam int unsigned IterW = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL_L = 7'b0000010,
    S_MUL_H = 7'b0000100,
    S_FOLD  = 7'b0001000,
    S_GAIN  = 7'b0010000,
    S_ROT   = 7'b0100000,
    S_ACC   = 7'b1000000
  } state_t;

  state_t      state;
  ddeo_job_t   job;
  logic [31:0] mag;        // |sum|, up to 2^32
  logic        mag_top;
  logic [63:0] plo;        // mag[31:0] * dpc, built from 16-bit limbs
  logic [32:0] phi;        // partial high * dpc (mag_top only)
  logic [31:0] h;
  logic signed [34:0] ds;
  logic signed [39:0] cx;
  logic signed [39:0] cy;
  logic signed [32:0] cz;
  logic [IterW-1:0]   iter;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic [31:0]        acc_heading;
  logic               out_valid;
  logic               out_rej;

  logic [15:0]        limb;
  logic [47:0]        limb_prod;
  logic [64:0]        prod_full;
  logic [47:0]        ds_raw;
  logic [33:0]        ds_mag;
  logic [31:0]        dth;
  logic signed [32:0] zs;
  logic signed [66:0] gprod;
  logic signed [39:0] xs;
  logic signed [39:0] ys;
  logic [31:0]        atan_v;
  logic signed [40:0] sx;
  logic signed [40:0] sy;
  logic signed [31:0] sat_x;
  logic signed [31:0] sat_y;

  function automatic logic [31:0] q_word(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  assign q_pop = (state == S_IDLE) && q_valid && !out_valid;

  // path-length product: one 16-bit limb of mag per cycle
  assign limb      = (state == S_MUL_L) ? mag[15:0] : mag[31:16];
  assign limb_prod = {32'd0, limb} * {16'd0, distance_per_count};
  assign prod_full = {1'b0, plo} + ({32'd0, phi} << 32);
  assign ds_raw    = prod_full[64:17];
  assign ds_mag    = (ds_raw > {14'd0, DsClamp}) ? DsClamp : ds_raw[33:0];
  assign dth       = q_word(job.diff[31:0], angle_per_count);
  assign zs        = $signed({h[31], h});
  assign gprod     = $signed(ds) * $signed({1'b0, GainQ30});
  assign xs        = cx >>> iter;
  assign ys        = cy >>> iter;
  assign atan_v    = atan_lookup(5'(iter));
  assign sx        = 41'(acc_x) + 41'(cx);
  assign sy        = 41'(acc_y) + 41'(cy);
  assign sat_x     = (sx > 41'sd2147483647) ? 32'sh7fffffff :
                     (sx < -41'sd2147483648) ? 32'sh80000000 : sx[31:0];
  assign sat_y     = (sy > 41'sd2147483647) ? 32'sh7fffffff :
                     (sy < -41'sd2147483648) ? 32'sh80000000 : sy[31:0];

  assign out_ch.valid           = out_valid;
  assign out_ch.pos_x           = acc_x;
  assign out_ch.pos_y           = acc_y;
  assign out_ch.heading         = acc_heading;
  assign out_ch.sample_rejected = out_rej;

  // sequence one job at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      out_rej     <= 1'b0;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            job <= q_data;
            if (q_data.rejected) begin
              out_rej   <= 1'b1;
              out_valid <= 1'b1;
            end else begin
              {mag_top, mag} <= q_data.sum[32] ? (33'd0 - q_data.sum) : q_data.sum;
              state <= S_MUL_L;
            end
          end
        end
        S_MUL_L: begin
          plo   <= {16'd0, limb_prod};
          phi   <= mag_top ? {1'b0, distance_per_count} : 33'd0;
          state <= S_MUL_H;
        end
        S_MUL_H: begin
          plo   <= plo + {limb_prod, 16'd0};
          h     <= acc_heading;
          state <= S_FOLD;
        end
        S_FOLD: begin
          h     <= acc_heading + dth;
          ds    <= job.sum[32] ? -$signed({1'b0, ds_mag}) : $signed({1'b0, ds_mag});
          state <= S_GAIN;
        end
        S_GAIN: begin
          // fold into the right half plane
          if (zs >= 33'sd1073741824 || zs < -33'sd1073741824) begin
            cx <= 40'(-gprod >>> 30);
            cz <= $signed({~h[31], ~h[31], h[30:0]});
          end else begin
            cx <= 40'(gprod >>> 30);
            cz <= zs;
          end
          cy    <= '0;
          iter  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (iter == IterW'(CORDIC_STEPS)) begin
            state <= S_ACC;
          end else begin
            if (!cz[32]) begin
              cx <= cx - ys;
              cy <= cy + xs;
              cz <= cz - $signed({1'b0, atan_v});
            end else begin
              cx <= cx + ys;
              cy <= cy - xs;
              cz <= cz + $signed({1'b0, atan_v});
            end
            iter <= iter + 1'b1;
          end
        end
        S_ACC: begin
          acc_x       <= sat_x;
          acc_y       <= sat_y;
          acc_heading <= h;
          out_rej     <= 1'b0;
          out_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/diff_drive_encoder_odometry_top.sv */
// ----------------------------------------------------------------------------
// diff_drive_encoder_odometry_top
// Differential-drive wheel odometry with a serial CORDIC pose update.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_ch     in   left_count, right_count
// out_ch    out  pos_x, pos_y, heading, sample_rejected
// apb       in   distance_per_count @0, angle_per_count @4, jump_limit @8
//
// An accepted sample steps through MUL_L, MUL_H, FOLD, GAIN, ROT and ACC in the
// back sequencer from pop to result beat, one rotation step per cycle in ROT;
// a rejected sample is answered at pop. A waiting result holds off the next pop.
// Reset clears pose and previous counts and restores register defaults.
// The front keeps taking samples into a two-entry queue while a result waits.
// ----------------------------------------------------------------------------
module diff_drive_encoder_odometry_top import ddeo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
  input  logic        clk,
  input  logic        rst,
  ddeo_in_if.sink     in_ch,
  ddeo_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] distance_per_count;
  logic [31:0] angle_per_count;
  logic [30:0] jump_limit;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  ddeo_job_t   q_in;
  ddeo_job_t   q_out;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_per_count <= DistPerCountReset;
      angle_per_count    <= AnglePerCountReset;
      jump_limit         <= JumpLimitReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        RegDistPerCount:  distance_per_count <= pwdata;
        RegAnglePerCount: angle_per_count    <= pwdata;
        RegJumpLimit:     jump_limit         <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      RegDistPerCount:  prdata = distance_per_count;
      RegAnglePerCount: prdata = angle_per_count;
      RegJumpLimit:     prdata = {1'b0, jump_limit};
      default:          prdata = '0;
    endcase
  end

  ddeo_front u_front (
    .clk, .rst, .in_ch, .jump_limit, .q_full, .q_push, .q_data(q_in)
  );

  ddeo_queue u_queue (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .pop_data(q_out)
  );

  ddeo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst, .q_valid, .q_data(q_out), .q_pop,
    .distance_per_count, .angle_per_count, .out_ch
  );

endmodule

/* dv/odometry_pose_checker.sv */
// ----------------------------------------------------------------------------
// odometry_pose_checker
// Watches the sample, pose and register ports of the odometry block. It tracks
// its own copy of the registers and pose, predicts each pose beat, and compares
// the beats field by field.
// ----------------------------------------------------------------------------
module odometry_pose_checker import ddeo_pkg::*; #(
  parameter int unsigned ROT_STEPS = CordicStepsDefault
) (
  input  logic        clk,
  input  logic        rst,
  ddeo_in_if          smp,
  ddeo_out_if         pose,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hdg;
    logic        rej;
  } pose_t;

  localparam longint GainQ30Val = 64'sd652032875;
  localparam longint ClampVal   = 64'sd8589934592;

  // binary-angle arctangent of 2^-i
  localparam logic [31:0] AtanTab [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

  logic [31:0] m_dist, m_ang, m_last_l, m_last_r, m_hdg;
  logic [30:0] m_jump;
  logic signed [31:0] m_x, m_y;
  pose_t expected_poses[$];

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] a, longint d);
    longint s;
    s = longint'(a) + d;
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // advance the pose model by one sample and return the pose beat it causes
  function automatic pose_t advance_pose(logic [31:0] l, logic [31:0] r);
    longint dl, dr, sum, ds, z, x, y, xs, ys;
    logic [63:0] mag, prod;
    logic [31:0] dth, h, diff;
    logic rej;
    pose_t p;
    dl = longint'($signed(m_last_l - l));
    dr = longint'($signed(m_last_r - r));
    rej = !(((dl < 0) ? -dl : dl) < longint'(m_jump) &&
            ((dr < 0) ? -dr : dr) < longint'(m_jump));
    if (!rej) begin
      sum = dl + dr;
      mag = (sum < 0) ? -sum : sum;
      prod = mag * {32'd0, m_dist};
      ds = longint'(prod >> 17);
      if (ds > ClampVal) ds = ClampVal;
      if (sum < 0) ds = -ds;
      diff = dr[31:0] - dl[31:0];
      dth = diff * m_ang;
      h = m_hdg + dth;
      z = longint'($signed(h));
      // fold into the right half plane
      if (z >= 64'sd1073741824 || z < -64'sd1073741824) begin
        z = longint'($signed(h - 32'h8000_0000));
        ds = -ds;
      end
      x = (ds * GainQ30Val) >>> 30;
      y = 0;
      for (int i = 0; i < ROT_STEPS && i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= longint'(AtanTab[i]);
        end else begin
          x += ys; y -= xs; z += longint'(AtanTab[i]);
        end
      end
      m_x = sat_sum(m_x, x);
      m_y = sat_sum(m_y, y);
      m_hdg = h;
    end
    m_last_l = l;
    m_last_r = r;
    p.x = m_x; p.y = m_y; p.hdg = m_hdg; p.rej = rej;
    return p;
  endfunction

  assign pending = expected_poses.size();

  always @(posedge clk) begin
    pose_t e;
    if (rst) begin
      m_dist = DistPerCountReset; m_ang = AnglePerCountReset;
      m_jump = JumpLimitReset;
      m_last_l = '0; m_last_r = '0; m_x = '0; m_y = '0; m_hdg = '0;
      expected_poses.delete();
      fail_count = 0;
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegDistPerCount:  m_dist = pwdata;
          RegAnglePerCount: m_ang = pwdata;
          RegJumpLimit:     m_jump = pwdata[30:0];
          default: ;
        endcase
      end
      if (smp.valid && smp.ready)
        expected_poses.push_back(advance_pose(smp.left_count, smp.right_count));
      // compare each pose beat with the oldest prediction
      if (pose.valid && pose.ready) begin
        if (expected_poses.size() == 0) begin
          $error("pose beat with nothing expected");
          fail_count++;
        end else begin
          e = expected_poses.pop_front();
          if (pose.pos_x !== e.x) begin
            $error("pos_x expected %0d got %0d", $signed(e.x), $signed(pose.pos_x));
            fail_count++;
          end
          if (pose.pos_y !== e.y) begin
            $error("pos_y expected %0d got %0d", $signed(e.y), $signed(pose.pos_y));
            fail_count++;
          end
          if (pose.heading !== e.hdg) begin
            $error("heading expected %h got %h", e.hdg, pose.heading);
            fail_count++;
          end
          if (pose.sample_rejected !== e.rej) begin
            $error("sample_rejected expected %b got %b", e.rej, pose.sample_rejected);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

/* dv/tb_diff_drive_encoder_odometry_top.sv */
// ----------------------------------------------------------------------------
// tb_diff_drive_encoder_odometry_top
// Drives encoder samples and register writes into the odometry block with
// random gaps and output stalls, in phases over several register settings.
// The checker predicts every pose beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_diff_drive_encoder_odometry_top import ddeo_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          hold_off_req = 0;
  logic [31:0] last_left = '0, last_right = '0;

  ddeo_in_if  smp();
  ddeo_out_if pose();

  diff_drive_encoder_odometry_top DUT (
    .clk, .rst, .in_ch(smp), .out_ch(pose),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  odometry_pose_checker u_checker (
    .clk, .rst, .smp, .pose, .psel, .penable, .pwrite, .paddr, .pwdata,
    .pready, .fail_count, .pending
  );

  always #5 clk = ~clk;

  initial begin
    smp.valid = 0; smp.left_count = '0; smp.right_count = '0;
    pose.ready = 0;
  end

  // register write: setup beat, then access beat
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // hold the sender until every pose beat has come back
  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
  endtask

  // offer one sample given as wheel deltas, then idle a random gap
  task automatic send_sample(logic [31:0] dl, logic [31:0] dr);
    int gap;
    last_left = last_left - dl;
    last_right = last_right - dr;
    smp.valid <= 1; smp.left_count <= last_left; smp.right_count <= last_right;
    do @(posedge clk); while (!smp.ready);
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 60);
    if (gap > 0) begin
      smp.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(int n, int lim);
    logic [31:0] a, b;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: begin a = $urandom; b = $urandom; end
        1: begin a = lim - $urandom_range(0, 1); b = -(lim - $urandom_range(0, 1)); end
        default: begin
          a = $urandom_range(0, 3000) - 1500;
          b = a + $urandom_range(0, 400) - 200;
        end
      endcase
      send_sample(a, b);
    end
    smp.valid <= 0;
  endtask

  // pose beat acceptance: random stalls, plus one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      if (hold_off_req) begin
        pose.ready <= 0;
        repeat (300) @(posedge clk);
        hold_off_req = 0;
      end else begin
        pose.ready <= ($urandom_range(0, 9) < 7);
        @(posedge clk);
        if ($urandom_range(0, 99) == 0) begin
          pose.ready <= 0;
          repeat ($urandom_range(20, 80)) @(posedge clk);
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((smp.valid && smp.ready) || (pose.valid && pose.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    repeat (2) @(posedge clk);

    // directed: reset settings, delta edges, jump edge, extreme counts
    send_sample(0, 0);
    send_sample(1, 1);
    send_sample(-1, 1);
    send_sample(11999, 11999);
    send_sample(12000, 0);
    send_sample(0, -12000);
    send_sample(-11999, 11999);
    send_sample(32'h8000_0000, 0);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(100, -100);
    send_sample(4000, -4000);
    send_sample(-4000, 4000);
    smp.valid <= 0;
    drain();

    // maximum scale, widest jump limit: clamp and saturation
    reg_write(RegDistPerCount, 32'hffff_ffff);
    reg_write(RegAnglePerCount, 32'h0123_4567);
    reg_write(RegJumpLimit, 32'h7fff_ffff);
    reg_write(2'd3, 32'hdead_beef);
    send_sample(32'h7fff_fff0, 32'h7fff_fff0);
    send_sample(32'h8000_0001, 32'h8000_0001);
    send_sample(32'h7fff_fffe, 32'h8000_0002);
    for (int k = 0; k < 6; k++) send_sample(32'h4000_0000, 32'h4000_0000);
    for (int k = 0; k < 6; k++) send_sample(32'hc000_0000, 32'hc000_0000);
    smp.valid <= 0;
    drain();

    // zero jump limit rejects everything
    reg_write(RegJumpLimit, 32'd0);
    send_random(40, 5);
    drain();

    // long output hold-off while samples keep coming
    reg_write(RegDistPerCount, 32'd65536);
    reg_write(RegAnglePerCount, 32'hffff_ffff);
    reg_write(RegJumpLimit, 32'd12000);
    hold_off_req = 1;
    send_random(100, 12000);
    drain();

    reg_write(RegDistPerCount, 32'd0);
    reg_write(RegAnglePerCount, 32'd0);
    send_random(60, 12000);
    drain();

    reg_write(RegDistPerCount, $urandom);
    reg_write(RegAnglePerCount, $urandom_range(0, 32'h00ff_ffff));
    reg_write(RegJumpLimit, 32'd3000);
    send_random(120, 3000);
    drain();

    reg_write(RegDistPerCount, 32'h8000_0000);
    reg_write(RegAnglePerCount, $urandom);
    reg_write(RegJumpLimit, 32'h7fff_ffff);
    send_random(130, 32'h7fff_ffff);
    drain();

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
